### src/sle_pkg.sv
`timescale 1ns / 1ps
package sle_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;

    // operation codes
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_SEARCH = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    // status codes
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] value;
    } sle_in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] index;
        logic [CNT_W-1:0] count;
    } sle_out_t;

    // broadcast from the control to every cell
    typedef struct packed {
        logic                         cmp;
        logic                         ins;
        logic                         rem;
        logic signed [DATA_WIDTH-1:0] cmp_key;
        logic signed [DATA_WIDTH-1:0] ins_key;
    } sle_ctrl_t;

    // compare flags a cell reports, all qualified by its valid bit
    typedef struct packed {
        logic le;
        logic lt;
        logic eq;
    } sle_flag_t;

    // position of the first clear bit of a thermometer vector, DEPTH if none
    function automatic logic [CNT_W-1:0] first_zero(input logic [DEPTH-1:0] v);
        logic [CNT_W-1:0] p;
        p = CNT_W'(DEPTH);
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (!v[i])
            begin
                p = CNT_W'(i);
            end
        end
        return p;
    endfunction

endpackage

### src/sle_cell.sv
`timescale 1ns / 1ps
module sle_cell (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sle_pkg::sle_ctrl_t                    ctrl,
    input  logic                                  valid,
    input  logic                                  left_le,
    input  logic signed [sle_pkg::DATA_WIDTH-1:0] left_entry,
    input  logic signed [sle_pkg::DATA_WIDTH-1:0] right_entry,
    output logic signed [sle_pkg::DATA_WIDTH-1:0] entry,
    output sle_pkg::sle_flag_t                    flags
);
    import sle_pkg::*;

    logic signed [DATA_WIDTH-1:0] entry_reg;
    logic signed [DATA_WIDTH-1:0] entry_next;
    sle_flag_t                    flags_reg;
    sle_flag_t                    flags_next;

    // compare the stored entry against the broadcast key
    always_comb
    begin
        flags_next    = flags_reg;
        if (ctrl.cmp)
        begin
            flags_next.le = valid && (entry_reg <= ctrl.cmp_key);
            flags_next.lt = valid && (entry_reg <  ctrl.cmp_key);
            flags_next.eq = valid && (entry_reg == ctrl.cmp_key);
        end
    end

    // shift up on insert, shift down on remove, hold otherwise
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins && !flags_reg.le)
        begin
            entry_next = left_le ? ctrl.ins_key : left_entry;
        end
        else if (ctrl.rem && !flags_reg.lt)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign flags = flags_reg;

endmodule

### src/sorted_list_engine.sv
`timescale 1ns / 1ps
// Sorted list of up to 16 signed values held in a row of compare-and-shift cells.
// done is registered from busy, which is registered when the beat is taken (compare, then shift).
// No new beat is taken while busy is high; busy marks the shift cycle, set by the
// dependence of each compare on the previous shift. The receiver cannot stall.
// Reset (rst_n low, asynchronous) empties the list and clears busy and done.
module sorted_list_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  sle_pkg::sle_in_t  cmd,
    output logic              busy,
    output logic              done,
    output sle_pkg::sle_out_t result
);
    import sle_pkg::*;

    logic                         busy_reg;
    logic                         busy_next;
    logic                         done_reg;
    logic                         done_next;
    logic [1:0]                   mode_reg;
    logic signed [DATA_WIDTH-1:0] key_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    sle_out_t                     result_reg;
    sle_out_t                     result_next;

    logic                         accept;
    sle_ctrl_t                    ctrl;
    logic [DEPTH-1:0]             valid;
    logic [DEPTH-1:0]             le_vec;
    logic [DEPTH-1:0]             lt_vec;
    logic [DEPTH-1:0]             eq_vec;
    logic signed [DATA_WIDTH-1:0] entry_w [DEPTH];
    sle_flag_t                    flag_w  [DEPTH];
    logic                         full;
    logic                         found;
    logic                         ins_go;
    logic                         rem_go;
    logic [CNT_W-1:0]             ins_pos;
    logic [CNT_W-1:0]             hit_pos;

    assign accept = start && !busy_reg;

    // drive the cell row
    always_comb
    begin
        ctrl.cmp     = accept;
        ctrl.ins     = ins_go;
        ctrl.rem     = rem_go;
        ctrl.cmp_key = cmd.value;
        ctrl.ins_key = key_reg;
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic                         left_le;
            logic signed [DATA_WIDTH-1:0] left_entry;
            logic signed [DATA_WIDTH-1:0] right_entry;

            assign valid[g]  = (CNT_W'(g) < count_reg);
            assign le_vec[g] = flag_w[g].le;
            assign lt_vec[g] = flag_w[g].lt;
            assign eq_vec[g] = flag_w[g].eq;

            if (g == 0)
            begin : g_first
                assign left_le    = 1'b1;
                assign left_entry = '0;
            end
            else
            begin : g_mid
                assign left_le    = flag_w[g-1].le;
                assign left_entry = entry_w[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_last
                assign right_entry = entry_w[g];
            end
            else
            begin : g_inner
                assign right_entry = entry_w[g+1];
            end

            sle_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .valid       (valid[g]),
                .left_le     (left_le),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .entry       (entry_w[g]),
                .flags       (flag_w[g])
            );
        end
    endgenerate

    // decide the operation from the registered flags
    always_comb
    begin
        full    = (count_reg == CNT_W'(DEPTH));
        found   = |eq_vec;
        ins_pos = first_zero(le_vec);
        hit_pos = first_zero(lt_vec);
        ins_go  = busy_reg && (mode_reg == MODE_INSERT) && !full;
        rem_go  = busy_reg && (mode_reg == MODE_REMOVE) && found;
    end

    // build the result beat and the next fill count
    always_comb
    begin
        busy_next   = accept;
        done_next   = busy_reg;
        count_next  = count_reg;
        result_next = result_reg;
        if (busy_reg)
        begin
            result_next.status = ST_MISS;
            result_next.index  = '0;
            case (mode_reg)
                MODE_INSERT:
                begin
                    if (full)
                    begin
                        result_next.status = ST_FULL;
                    end
                    else
                    begin
                        result_next.status = ST_DONE;
                        result_next.index  = ins_pos[IDX_W-1:0];
                        count_next         = count_reg + CNT_W'(1);
                    end
                end
                MODE_SEARCH, MODE_REMOVE:
                begin
                    if (found)
                    begin
                        result_next.status = ST_DONE;
                        result_next.index  = hit_pos[IDX_W-1:0];
                        if (mode_reg == MODE_REMOVE)
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                end
                default:
                begin
                    result_next.status = ST_MISS;
                end
            endcase
            result_next.count = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // hold the beat payload and register the result beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= cmd.mode;
            key_reg  <= cmd.value;
        end
        result_reg <= result_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

### src/sle_checker.sv
`timescale 1ns / 1ps
module sle_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input sle_pkg::sle_out_t result
);
    import sle_pkg::*;

    // a taken beat occupies the engine in the next cycle
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted beat");

    // every busy cycle ends in exactly one result beat
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("result beat missing after busy cycle");

    // count never exceeds capacity
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.count <= CNT_W'(DEPTH)))
        else $error("count beyond capacity");

    // failed operations report index zero
    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != ST_DONE)) |-> (result.index == '0))
        else $error("nonzero index on a failed operation");

    // a rejected insert only happens on a full list
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_FULL)) |-> (result.count == CNT_W'(DEPTH)))
        else $error("insert rejected while list not full");

endmodule

bind sorted_list_engine sle_checker u_sle_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

### tb/sorted_list_engine_test.sv
`timescale 1ns / 1ps
module sorted_list_engine_test;
    import sle_pkg::*;

    // the one encoding the block leaves unused
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_CMDS  = 1500;
    localparam int NUM_PHASES   = 4;
    localparam int DRAIN_CYCLES = 2000;

    logic     clk;
    logic     rst_n;
    logic     start = 1'b0;
    sle_in_t  cmd   = '0;
    logic     busy;
    logic     done;
    sle_out_t result;

    sle_in_t  cmd_q[$];
    sle_out_t expected_q[$];
    int       send_idle_pct;

    // shadow copy of the list, kept in ascending order
    logic signed [DATA_WIDTH-1:0] list_vals[DEPTH];
    int list_len;
    int peak_len;

    int errors;
    int beats_sent;
    int results_seen;
    int n_done;
    int n_full;
    int n_miss;

    sorted_list_engine DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #500000;
        $display("timeout with %0d results outstanding", expected_q.size());
        $display("sorted_list_engine regression: fail");
        $finish;
    end

    // Apply one command to the shadow list and return the result it must produce.
    function automatic sle_out_t apply_cmd(sle_in_t c);
        sle_out_t r;
        logic signed [DATA_WIDTH-1:0] key;
        int hit;
        int pos;
        key      = c.value;
        r.status = ST_MISS;
        r.index  = '0;
        hit      = -1;
        for (int i = 0; i < list_len; i++)
        begin
            if (hit < 0 && list_vals[i] == key)
            begin
                hit = i;
            end
        end
        case (c.mode)
            MODE_INSERT:
            begin
                if (list_len >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    // shift larger entries up; equal entries stay below the new one
                    pos = list_len;
                    while (pos > 0 && key < list_vals[pos-1])
                    begin
                        list_vals[pos] = list_vals[pos-1];
                        pos--;
                    end
                    list_vals[pos] = key;
                    list_len++;
                    r.status = ST_DONE;
                    r.index  = IDX_W'(pos);
                end
            end
            MODE_SEARCH:
            begin
                if (hit >= 0)
                begin
                    r.status = ST_DONE;
                    r.index  = IDX_W'(hit);
                end
            end
            MODE_REMOVE:
            begin
                if (hit >= 0)
                begin
                    // close the gap left by the first equal entry
                    for (int i = hit + 1; i < list_len; i++)
                    begin
                        list_vals[i-1] = list_vals[i];
                    end
                    list_len--;
                    r.status = ST_DONE;
                    r.index  = IDX_W'(hit);
                end
            end
            default:
            begin
            end
        endcase
        r.count = CNT_W'(list_len);
        if (list_len > peak_len)
        begin
            peak_len = list_len;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        if (errors < 50)
        begin
            $display("mismatch on result %0d: %s expected %0d, got %0d",
                     results_seen, what, want, got);
        end
        errors++;
    endtask

    task automatic queue_cmd(logic [1:0] mode, logic signed [31:0] value);
        sle_in_t c;
        c.mode  = mode;
        c.value = value;
        cmd_q.push_back(c);
    endtask

    // Random command: small value pool so searches and removes hit often.
    function automatic sle_in_t random_cmd(int insert_pct);
        sle_in_t c;
        int roll;
        int pick;
        roll = $urandom_range(99);
        if (roll < 3)
        begin
            c.mode = MODE_UNUSED;
        end
        else if (roll < 3 + insert_pct * 97 / 100)
        begin
            c.mode = MODE_INSERT;
        end
        else
        begin
            c.mode = $urandom_range(1) ? MODE_SEARCH : MODE_REMOVE;
        end
        pick = $urandom_range(9);
        if (pick < 6)
        begin
            c.value = $signed($urandom_range(8)) - 4;
        end
        else if (pick == 6)
        begin
            case ($urandom_range(3))
                0: c.value = 32'sh7FFF_FFFF;
                1: c.value = 32'sh8000_0000;
                2: c.value = -32'sd1;
                default: c.value = 32'sd0;
            endcase
        end
        else
        begin
            c.value = $urandom;
        end
        return c;
    endfunction

    // Driver: hold a beat until taken, then predict it and load the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd   <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_q.push_back(apply_cmd(cmd));
                beats_sent++;
            end
            if (start && busy)
            begin
                start <= 1'b1;
            end
            else if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                start <= 1'b1;
                cmd   <= cmd_q.pop_front();
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: check each strobed result against the oldest prediction.
    always @(posedge clk)
    begin : result_check
        sle_out_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected result, count", -1, result.count);
            end
            else
            begin
                want = expected_q.pop_front();
                if (result.status != want.status)
                begin
                    report_mismatch("status", want.status, result.status);
                end
                if (result.index != want.index)
                begin
                    report_mismatch("index", want.index, result.index);
                end
                if (result.count != want.count)
                begin
                    report_mismatch("count", want.count, result.count);
                end
                case (want.status)
                    ST_DONE: n_done++;
                    ST_FULL: n_full++;
                    default: n_miss++;
                endcase
            end
        end
    end

    // Stimulus: directed corners, then random bursts over several idle settings.
    initial
    begin : stimulus
        int idle_set[NUM_PHASES];
        int per_phase;
        int queued;
        int insert_pct;
        int wait_cycles;
        sle_in_t c;
        idle_set      = '{0, 77, 0, 30};
        per_phase     = RANDOM_CMDS / NUM_PHASES;
        send_idle_pct = 0;
        list_len      = 0;
        peak_len      = 0;
        @(posedge rst_n);
        @(negedge clk);

        // empty list and the unused encoding
        queue_cmd(MODE_SEARCH, 32'sd0);
        queue_cmd(MODE_REMOVE, 32'sd0);
        queue_cmd(MODE_UNUSED, 32'sh5A5A_A5A5);
        // fill to capacity with extremes and duplicates
        queue_cmd(MODE_INSERT, 32'sh7FFF_FFFF);
        queue_cmd(MODE_INSERT, 32'sh8000_0000);
        queue_cmd(MODE_INSERT, 32'sd0);
        queue_cmd(MODE_INSERT, -32'sd1);
        queue_cmd(MODE_INSERT, 32'sd5);
        queue_cmd(MODE_INSERT, 32'sd5);
        queue_cmd(MODE_INSERT, -32'sd5);
        queue_cmd(MODE_INSERT, 32'sd1);
        queue_cmd(MODE_INSERT, 32'sh4000_0000);
        queue_cmd(MODE_INSERT, 32'shC000_0000);
        queue_cmd(MODE_INSERT, 32'sd7);
        queue_cmd(MODE_INSERT, 32'sd5);
        queue_cmd(MODE_INSERT, 32'sd3);
        queue_cmd(MODE_INSERT, -32'sd2);
        queue_cmd(MODE_INSERT, 32'sd2);
        queue_cmd(MODE_INSERT, 32'sd100);
        // full list rejects, then lookups and removals
        queue_cmd(MODE_INSERT, 32'sd4);
        queue_cmd(MODE_SEARCH, 32'sd5);
        queue_cmd(MODE_SEARCH, 32'sd6);
        queue_cmd(MODE_REMOVE, 32'sh8000_0000);
        queue_cmd(MODE_REMOVE, 32'sh7FFF_FFFF);
        queue_cmd(MODE_REMOVE, 32'sd6);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // hold off until the block has returned everything
            while (cmd_q.size() != 0 || start || expected_q.size() != 0)
            begin
                @(negedge clk);
            end
            send_idle_pct = idle_set[p];
            queued = 0;
            while (queued < per_phase)
            begin
                case ($urandom_range(3))
                    0: insert_pct = 25;
                    1: insert_pct = 50;
                    2: insert_pct = 75;
                    default: insert_pct = 90;
                endcase
                for (int k = 0; k < 50 && queued < per_phase; k++)
                begin
                    c = random_cmd(insert_pct);
                    cmd_q.push_back(c);
                    if (c.mode != MODE_UNUSED)
                    begin
                        queued++;
                    end
                end
                // let the driver catch up before the next burst
                while (cmd_q.size() > 20)
                begin
                    @(negedge clk);
                end
            end
        end

        // drain, then allow for the compare and shift cycles
        wait_cycles = 0;
        while ((cmd_q.size() != 0 || start || expected_q.size() != 0)
               && wait_cycles < DRAIN_CYCLES)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (4) @(negedge clk);
        if (expected_q.size() != 0)
        begin
            report_mismatch("results never returned", 0, expected_q.size());
        end

        $display("%0d commands over %0d idle settings: %0d done, %0d full, %0d not found",
                 beats_sent, NUM_PHASES, n_done, n_full, n_miss);
        $display("peak fill %0d of %0d, %0d mismatches", peak_len, DEPTH, errors);
        if (errors == 0)
        begin
            $display("sorted_list_engine regression: pass");
        end
        else
        begin
            $display("sorted_list_engine regression: fail");
        end
        $finish;
    end

endmodule
